// ----- rtl/rab_pkg.sv -----
// Shared constants for the range and bearing pipeline: field widths,
// CORDIC arctangent table, fixed-point scale factors and pipeline latency.
// No dependencies.
`default_nettype none
package rab_pkg;

	localparam int COORD_WIDTH   = 20;
	localparam int CORDIC_STAGES = 16;

	// Difference vector plus CORDIC growth (gain < 1.65, times sqrt 2)
	localparam int XY_W   = COORD_WIDTH + 3;
	localparam int PIX_W  = XY_W - 1;
	localparam int NM_W   = 24;
	localparam int DIST_W = 24;
	localparam int BEAR_W = 25;
	localparam int Z_W    = 26;
	localparam int ATAN_W = 22;
	localparam int KINV_W = 24;

	localparam int P1_W = PIX_W + KINV_W + 1;
	localparam int P2_W = PIX_W + NM_W;
	localparam int Q_W  = P2_W + 1 - 16;

	// start accepted to done: input stage, CORDIC stages, two multiply stages, output
	localparam int LATENCY = CORDIC_STAGES + 4;

	localparam logic [NM_W-1:0]       NM_RESET  = NM_W'(65536);
	localparam logic [KINV_W-1:0]     KINV_Q24  = KINV_W'(10188014);
	localparam logic [P1_W-1:0]       ROUND24   = P1_W'(1) << 23;
	localparam logic [P2_W:0]         ROUND16   = (P2_W + 1)'(1) << 15;
	localparam logic signed [Z_W-1:0] DEG90_Q16  = Z_W'(5898240);
	localparam logic signed [Z_W-1:0] DEG360_Q16 = Z_W'(23592960);
	localparam logic [BEAR_W-1:0]     DEG270_Q16 = BEAR_W'(17694720);
	localparam logic [DIST_W-1:0]     DIST_MAX   = '1;

	// atan(2^-i) in degrees, Q16
	localparam logic [ATAN_W-1:0] ATAN_TAB [0:31] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379,  22'd117304,  22'd58666,  22'd29335,
		22'd14668,   22'd7334,    22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,
		22'd57,      22'd29,      22'd14,     22'd7,
		22'd4,       22'd2,       22'd1,      22'd0,
		22'd0,       22'd0,       22'd0,      22'd0,
		22'd0,       22'd0,       22'd0,      22'd0
	};

endpackage
`default_nettype wire

// ----- rtl/range_and_bearing_top.sv -----
// Range and bearing between two screen points: unrolled CORDIC vectoring pipeline.
// Depends on rab_pkg.
`default_nettype none
// One point pair is taken on every clock at which start is high; busy stays
// low. Each result appears on distance_nm and bearing_deg for one cycle with
// done high, in order. Between start and done lie the input register, one
// register per CORDIC iteration, the two multiply stages and the output
// register.
// The receiver has no backpressure: capture results when done is high.
// nm_per_pixel (unsigned 8.16) is written through cfg_valid/cfg_data, which
// is always ready; write it only while no result is pending.
module range_and_bearing_top (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	output logic                                  busy,
	input  wire  signed [rab_pkg::COORD_WIDTH-1:0] a_x,
	input  wire  signed [rab_pkg::COORD_WIDTH-1:0] a_y,
	input  wire  signed [rab_pkg::COORD_WIDTH-1:0] b_x,
	input  wire  signed [rab_pkg::COORD_WIDTH-1:0] b_y,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire         [rab_pkg::NM_W-1:0]        cfg_data,
	output logic                                  done,
	output logic        [rab_pkg::DIST_W-1:0]      distance_nm,
	output logic        [rab_pkg::BEAR_W-1:0]      bearing_deg
);

	localparam int N     = rab_pkg::CORDIC_STAGES;
	localparam int XY_W  = rab_pkg::XY_W;
	localparam int Z_W   = rab_pkg::Z_W;
	localparam int CW    = rab_pkg::COORD_WIDTH;
	localparam int EXT   = XY_W - CW;

	logic [rab_pkg::NM_W-1:0] nm_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nm_q <= rab_pkg::NM_RESET;
		end else if (cfg_valid) begin
			nm_q <= cfg_data;
		end
	end

	// ---------------- input stage: difference and quadrant pre-rotation
	logic signed [XY_W-1:0] ax_e, ay_e, bx_e, by_e, dx_c, dy_c;
	logic signed [XY_W-1:0] x0_c, y0_c;
	logic signed [Z_W-1:0]  z0_c;

	// CORDIC stage registers; index 0 is the input stage
	logic signed [XY_W-1:0] cx_s [0:N];
	logic signed [XY_W-1:0] cy_s [0:N];
	logic signed [Z_W-1:0]  cz_s [0:N];
	logic                   cnull_s [0:N];
	logic                   cv_s [0:N];

	always_comb begin
		ax_e = {{EXT{a_x[CW-1]}}, a_x};
		ay_e = {{EXT{a_y[CW-1]}}, a_y};
		bx_e = {{EXT{b_x[CW-1]}}, b_x};
		by_e = {{EXT{b_y[CW-1]}}, b_y};
		dx_c = ax_e - bx_e;
		dy_c = ay_e - by_e;
		x0_c = dx_c;
		y0_c = dy_c;
		z0_c = '0;
		if (dx_c < 0) begin
			if (dy_c >= 0) begin
				x0_c = dy_c;
				y0_c = -dx_c;
				z0_c = rab_pkg::DEG90_Q16;
			end else begin
				x0_c = -dy_c;
				y0_c = dx_c;
				z0_c = -rab_pkg::DEG90_Q16;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else begin
			cv_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]    <= x0_c;
		cy_s[0]    <= y0_c;
		cz_s[0]    <= z0_c;
		cnull_s[0] <= (dx_c == 0) && (dy_c == 0);
	end

	// ---------------- CORDIC vectoring, one iteration per register
	for (genvar i = 0; i < N; i++) begin : g_cordic
		logic signed [XY_W-1:0] xs_c, ys_c;
		logic signed [Z_W-1:0]  t_c;

		assign xs_c = cx_s[i] >>> i;
		assign ys_c = cy_s[i] >>> i;
		assign t_c  = {{(Z_W - rab_pkg::ATAN_W){1'b0}}, rab_pkg::ATAN_TAB[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			cnull_s[i+1] <= cnull_s[i];
			if (cy_s[i] >= 0) begin
				cx_s[i+1] <= cx_s[i] + ys_c;
				cy_s[i+1] <= cy_s[i] - xs_c;
				cz_s[i+1] <= cz_s[i] + t_c;
			end else begin
				cx_s[i+1] <= cx_s[i] - ys_c;
				cy_s[i+1] <= cy_s[i] + xs_c;
				cz_s[i+1] <= cz_s[i] - t_c;
			end
		end
	end

	// ---------------- stage m1: gain correction, bearing offset
	logic [rab_pkg::PIX_W-1:0] xpos_c;
	logic [rab_pkg::P1_W-1:0]  p1_c;
	logic [rab_pkg::PIX_W-1:0] pix_m1;
	logic signed [Z_W-1:0]     bz_m1;
	logic                      null_m1, v_m1;

	assign xpos_c = cx_s[N][XY_W-1] ? '0 : cx_s[N][XY_W-2:0];
	assign p1_c   = rab_pkg::P1_W'(xpos_c) * rab_pkg::P1_W'(rab_pkg::KINV_Q24)
		+ rab_pkg::ROUND24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
		end else begin
			v_m1 <= cv_s[N];
		end
	end

	always_ff @(posedge clk) begin
		pix_m1  <= p1_c[24 +: rab_pkg::PIX_W];
		bz_m1   <= cz_s[N] - rab_pkg::DEG90_Q16;
		null_m1 <= cnull_s[N];
	end

	// ---------------- stage m2: scale to miles, wrap bearing
	logic [rab_pkg::P2_W-1:0]   p2_m2;
	logic [rab_pkg::BEAR_W-1:0] bear_m2;
	logic                       v_m2;
	logic signed [Z_W-1:0]      wrap_c;

	always_comb begin
		wrap_c = bz_m1;
		if (wrap_c < 0) begin
			wrap_c = wrap_c + rab_pkg::DEG360_Q16;
		end
		if (wrap_c >= rab_pkg::DEG360_Q16) begin
			wrap_c = wrap_c - rab_pkg::DEG360_Q16;
		end
		if (wrap_c < 0) begin
			wrap_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m2 <= 1'b0;
		end else begin
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		p2_m2   <= rab_pkg::P2_W'(pix_m1) * rab_pkg::P2_W'(nm_q);
		// coincident points report atan2(0, 0) = 0, i.e. 270 degrees
		bear_m2 <= null_m1 ? rab_pkg::DEG270_Q16 : wrap_c[rab_pkg::BEAR_W-1:0];
	end

	// ---------------- output: round, saturate
	logic [rab_pkg::P2_W:0]  sum_c;
	logic [rab_pkg::Q_W-1:0] q_c;
	logic                    done_q;
	logic [rab_pkg::DIST_W-1:0] dist_q;
	logic [rab_pkg::BEAR_W-1:0] bear_q;

	assign sum_c = {1'b0, p2_m2} + rab_pkg::ROUND16;
	assign q_c   = sum_c[rab_pkg::P2_W:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (|q_c[rab_pkg::Q_W-1:rab_pkg::DIST_W]) begin
			dist_q <= rab_pkg::DIST_MAX;
		end else begin
			dist_q <= q_c[rab_pkg::DIST_W-1:0];
		end
		bear_q <= bear_m2;
	end

	assign done        = done_q;
	assign distance_nm = dist_q;
	assign bearing_deg = bear_q;

endmodule
`default_nettype wire

// ----- rtl/rab_check.sv -----
// Port-level checks for range_and_bearing_top, attached by bind.
// Depends on rab_pkg.
`default_nettype none
module rab_check (
	input wire                                   clk,
	input wire                                   arst_n,
	input wire                                   start,
	input wire                                   busy,
	input wire  signed [rab_pkg::COORD_WIDTH-1:0] a_x,
	input wire  signed [rab_pkg::COORD_WIDTH-1:0] a_y,
	input wire  signed [rab_pkg::COORD_WIDTH-1:0] b_x,
	input wire  signed [rab_pkg::COORD_WIDTH-1:0] b_y,
	input wire                                   done,
	input wire         [rab_pkg::DIST_W-1:0]      distance_nm,
	input wire         [rab_pkg::BEAR_W-1:0]      bearing_deg
);

	localparam int L = rab_pkg::LATENCY;

	// every accepted word comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##L done)
		else $error("result missing after accepted word");

	// no result without a matching accepted word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, L))
		else $error("result without accepted word");

	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> bearing_deg < rab_pkg::BEAR_W'(23592960))
		else $error("bearing out of range");

	a_coincident: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && a_x == b_x && a_y == b_y |-> ##L
		(distance_nm == '0 && bearing_deg == rab_pkg::DEG270_Q16))
		else $error("coincident points give wrong result");

endmodule

bind range_and_bearing_top rab_check u_rab_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.a_x         (a_x),
	.a_y         (a_y),
	.b_x         (b_x),
	.b_y         (b_y),
	.done        (done),
	.distance_nm (distance_nm),
	.bearing_deg (bearing_deg)
);
`default_nettype wire
